@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold cond on every clock edge outside reset
`define ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dris_pkg.sv @@
// ----------------------------------------------------------------------------
// dris_pkg
// Constants, codes and command type for the ordered register id set.
// ----------------------------------------------------------------------------
`default_nettype none

package dris_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int ID_W        = 8;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

   localparam logic [7:0]      ABSENT_POS    = 8'hFF;
   localparam logic [ID_W-1:0] INVALID_RESET = 8'hFF;

   typedef struct packed {
      logic load;
      logic search;
      logic read;
   } ctl_cmd_type;

endpackage

`default_nettype wire

@@ rtl/dris_ctrl.sv @@
// ----------------------------------------------------------------------------
// dris_ctrl
// Sequencer: accept a word, search and update the store, read and present.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dris_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output dris_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       out_free;
   logic       accept;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = !reset &&
                       ((state_ff == ST_IDLE) || ((state_ff == ST_READ) && out_free));
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd.load   = accept;
      cmd.search = (state_ff == ST_SEARCH);
      cmd.read   = (state_ff == ST_READ) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (out_free) state_in = accept ? ST_SEARCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.read) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
      else rsp_tvalid_in = rsp_tvalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `ASSERT_NEXT(a_accept_to_search, req_tvalid && req_tready, state_ff == ST_SEARCH,
      "accepted word did not start a search")
   `ASSERT_NEXT(a_search_to_read, state_ff == ST_SEARCH, state_ff == ST_READ,
      "search not followed by read")
   `ASSERT_NEXT(a_read_holds, (state_ff == ST_READ) && rsp_tvalid_ff && !rsp_tready,
      (state_ff == ST_READ) && rsp_tvalid_ff, "read left while result stalled")

endmodule

`default_nettype wire

@@ rtl/dris_dpath.sv @@
// ----------------------------------------------------------------------------
// dris_dpath
// Id store with parallel match, compaction on remove, append on insert,
// indexed read and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dris_dpath (
   input  wire                               clock,
   input  wire                               reset,
   input  dris_pkg::ctl_cmd_type             cmd,
   input  wire                               csr_wr_en,
   input  wire  [dris_pkg::ID_W-1:0]         csr_wr_data,
   input  wire  [dris_pkg::MODE_W-1:0]       req_mode,
   input  wire  [dris_pkg::REQ_DATA_W-1:0]   req_data,
   output logic [dris_pkg::RSP_DATA_W-1:0]   rsp_data
);

   localparam int N = dris_pkg::MAX_ENTRIES;

   logic [dris_pkg::MODE_W-1:0] mode_ff;
   logic [dris_pkg::ID_W-1:0]   id_ff;
   logic [7:0]                  ridx_ff;
   logic [dris_pkg::ID_W-1:0]   invalid_ff;

   logic [dris_pkg::ID_W-1:0]   store_ff [N];
   logic [dris_pkg::ID_W-1:0]   store_in [N];
   logic [dris_pkg::CNT_W-1:0]  count_ff, count_in;

   logic                        present_ff, present_in;
   logic [7:0]                  pos_ff, pos_in;
   logic                        ovf_ff, ovf_in;
   logic [dris_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [N-1:0]                match;
   logic [dris_pkg::IDX_W-1:0]  hit_idx;
   logic                        is_new;
   logic                        full;
   logic                        do_insert;
   logic                        do_remove;
   logic [dris_pkg::ID_W-1:0]   entry_at;

   always_comb begin
      match   = '0;
      hit_idx = '0;
      for (int k = 0; k < N; k++) begin
         match[k] = (dris_pkg::CNT_W'(k) < count_ff) && (store_ff[k] == id_ff);
      end
      for (int k = N - 1; k >= 0; k--) begin
         if (match[k]) hit_idx = dris_pkg::IDX_W'(k);
      end
   end

   assign present_in = |match;
   assign pos_in     = present_in ? 8'(hit_idx) : dris_pkg::ABSENT_POS;
   assign full       = (count_ff == dris_pkg::CNT_W'(N));
   assign is_new     = (mode_ff == dris_pkg::MODE_INSERT) && (id_ff != invalid_ff) && !present_in;
   assign do_insert  = is_new && !full;
   assign ovf_in     = is_new && full;
   assign do_remove  = (mode_ff == dris_pkg::MODE_REMOVE) && present_in;

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      if (do_remove) begin
         for (int k = 0; k < N - 1; k++) begin
            if (dris_pkg::IDX_W'(k) >= hit_idx) store_in[k] = store_ff[k + 1];
         end
         count_in = count_ff - 1'b1;
      end else if (do_insert) begin
         for (int k = 0; k < N; k++) begin
            if (dris_pkg::CNT_W'(k) == count_ff) store_in[k] = id_ff;
         end
         count_in = count_ff + 1'b1;
      end
   end

   assign entry_at = (ridx_ff < 8'(count_ff))
                     ? store_ff[ridx_ff[dris_pkg::IDX_W-1:0]] : invalid_ff;

   assign rsp_data_in = {6'd0, ovf_ff, entry_at, 8'(count_ff), pos_ff, present_ff};
   assign rsp_data    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         invalid_ff <= dris_pkg::INVALID_RESET;
      end else begin
         if (cmd.search) count_ff <= count_in;
         if (csr_wr_en) invalid_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_data[7:0];
         ridx_ff <= req_data[15:8];
      end
      if (cmd.search) begin
         store_ff   <= store_in;
         present_ff <= present_in;
         pos_ff     <= pos_in;
         ovf_ff     <= ovf_in;
      end
      if (cmd.read) rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_HOLDS(a_count_bound, count_ff <= dris_pkg::CNT_W'(N),
      "entry count beyond store depth")
   `ASSERT_NEXT(a_remove_shrinks, cmd.search && do_remove,
      count_ff == dris_pkg::CNT_W'($past(count_ff) - 1'b1), "remove did not shrink count")

endmodule

`default_nettype wire

@@ rtl/dedup_register_id_set.sv @@
// ----------------------------------------------------------------------------
// dedup_register_id_set
// Ordered set of register ids without duplicates: insert, remove, query.
// ----------------------------------------------------------------------------
// Each word is registered, then searched and the id store updated, then the
// indexed read of the updated store registers the result word onto rsp_ once
//   the output register is free; a new word is accepted in that read step.
// A finished result waits in the output register while the next word runs.
// Reset empties the set and restores invalid_id to 255; no clearing pass.
`default_nettype none

module dedup_register_id_set (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [7:0]  csr_wr_data,   // invalid_id
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,     // reg_id[7:0], read_index[15:8]
   input  wire  [1:0]  req_tuser,     // mode[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata      // was_present[0], position[8:1],
                                      // entry_count[16:9], entry_at[24:17],
                                      // overflow[25], zero[31:26]
);

   dris_pkg::ctl_cmd_type cmd;

   dris_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dris_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mode    (req_tuser),
      .req_data    (req_tdata),
      .rsp_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dedup_register_id_set. A directed table walks the
// empty, full and compaction cases, then random insert/remove/query words
// from a small id pool fill and drain the set under several invalid_id
// settings. Every result word is compared against a behavioural copy of the
// ordered set or a typed table word, with bursty requests and a patterned response stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [dris_pkg::MODE_W-1:0] MODE_QUERY = 2'd2;
   localparam logic [dris_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int POOL_SIZE       = 24;
   localparam int WORDS_PER_PHASE = 275;
   localparam int PHASES          = 6;

   typedef struct packed {
      logic       was_present;
      logic [7:0] position;
      logic [7:0] entry_count;
      logic [7:0] entry_at;
      logic       overflow;
   } set_result_type;

   typedef struct {
      logic [dris_pkg::MODE_W-1:0] mode;
      logic [dris_pkg::ID_W-1:0]   reg_id;
      logic [7:0]                  read_index;
      bit                          typed;
      set_result_type              want;
   } set_step_type;

   localparam set_result_type EMPTY_RESULT =
      '{1'b0, dris_pkg::ABSENT_POS, 8'd0, dris_pkg::INVALID_RESET, 1'b0};
   localparam set_result_type FULL_DROP    =
      '{1'b0, dris_pkg::ABSENT_POS, 8'd16, dris_pkg::INVALID_RESET, 1'b1};
   localparam set_result_type ANY_RESULT   = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [dris_pkg::ID_W-1:0] set_ids [dris_pkg::MAX_ENTRIES];
   int                        set_count = 0;
   logic [dris_pkg::ID_W-1:0] invalid_id_q = dris_pkg::INVALID_RESET;

   set_result_type pending_set_results [$];
   set_step_type   directed_steps [$];
   int             mismatches = 0;
   int             burst_left = 0;
   logic [15:0]    stall_bits = 16'd0;
   int             stall_left = 0;

   dedup_register_id_set u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic set_result_type apply_set_op(input logic [dris_pkg::MODE_W-1:0] mode,
                                                   input logic [dris_pkg::ID_W-1:0] id,
                                                   input logic [7:0] idx);
      set_result_type r;
      int pos;
      pos = -1;
      for (int k = 0; k < set_count; k++)
         if (pos < 0 && set_ids[k] == id) pos = k;
      r.was_present = (pos >= 0);
      r.position    = (pos >= 0) ? 8'(pos) : dris_pkg::ABSENT_POS;
      r.overflow    = 1'b0;
      if (mode == dris_pkg::MODE_INSERT) begin
         if (id != invalid_id_q && pos < 0) begin
            if (set_count < dris_pkg::MAX_ENTRIES) begin
               set_ids[set_count] = id;
               set_count++;
            end else begin
               r.overflow = 1'b1;
            end
         end
      end else if (mode == dris_pkg::MODE_REMOVE) begin
         if (pos >= 0) begin
            for (int k = pos; k + 1 < set_count; k++) set_ids[k] = set_ids[k + 1];
            set_count--;
         end
      end
      r.entry_count = 8'(set_count);
      r.entry_at    = (int'(idx) < set_count) ? set_ids[idx] : invalid_id_q;
      return r;
   endfunction

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_set_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_invalid_id(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      invalid_id_q = value;
   endtask

   task automatic drive_req(input logic [dris_pkg::MODE_W-1:0] mode,
                            input logic [dris_pkg::ID_W-1:0] id,
                            input logic [7:0] idx, input bit typed,
                            input set_result_type want);
      set_result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {idx, id};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_set_op(mode, id, idx);
      pending_set_results.push_back(typed ? want : r);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic compare_result(input logic [31:0] word);
      set_result_type want;
      want = pending_set_results.pop_front();
      if (word[0] !== want.was_present) begin
         $error("was_present: expected %0d, got %0d", want.was_present, word[0]);
         mismatches++;
      end
      if (word[8:1] !== want.position) begin
         $error("position: expected %0d, got %0d", want.position, word[8:1]);
         mismatches++;
      end
      if (word[16:9] !== want.entry_count) begin
         $error("entry_count: expected %0d, got %0d", want.entry_count, word[16:9]);
         mismatches++;
      end
      if (word[24:17] !== want.entry_at) begin
         $error("entry_at: expected %0h, got %0h", want.entry_at, word[24:17]);
         mismatches++;
      end
      if (word[25] !== want.overflow) begin
         $error("overflow: expected %0d, got %0d", want.overflow, word[25]);
         mismatches++;
      end
      if (word[31:26] !== 6'd0) begin
         $error("pad: expected 0, got %0h", word[31:26]);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_set_results.size() == 0) begin
            $error("result word %0h with nothing outstanding", rsp_tdata);
            mismatches++;
         end else begin
            compare_result(rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left = 16;
         case ($urandom_range(0, 4))
            0, 1: stall_bits = 16'hFFFF;
            2: stall_bits = 16'($urandom);
            3: stall_bits = 16'($urandom) | 16'($urandom);
            default: stall_bits = 16'h0F0F;
         endcase
      end
      rsp_tready <= stall_bits[0];
      stall_bits = {stall_bits[0], stall_bits[15:1]};
      stall_left--;
   end

   initial begin
      #6_000_000;
      $display("dedup_register_id_set verification failed");
      $finish;
   end

   initial begin
      logic [dris_pkg::ID_W-1:0] id_pool [POOL_SIZE];
      logic [dris_pkg::MODE_W-1:0] mode;
      logic [dris_pkg::ID_W-1:0] id;
      logic [7:0] idx;
      logic [7:0] cfg;
      int sel;
      int insert_bias;
      int drain_cycles;

      directed_steps.push_back('{MODE_QUERY,            8'h00, 8'h00, 1'b1, EMPTY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'hFF, 8'hFF, 1'b1, EMPTY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_REMOVE, 8'h12, 8'h00, 1'b1, EMPTY_RESULT});
      directed_steps.push_back('{MODE_SPARE,            8'h00, 8'h00, 1'b1, EMPTY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h00, 8'h00, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h00, 8'h00, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h01, 8'h01, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h80, 8'h02, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'hFE, 8'h80, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h7F, 8'h03, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h55, 8'h7F, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'hAA, 8'h05, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h10, 8'h40, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h20, 8'h07, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h40, 8'h20, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h02, 8'h09, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h04, 8'h10, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h08, 8'h0B, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'hC3, 8'h08, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h3C, 8'h0D, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'hF0, 8'h0F, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h99, 8'hFF, 1'b1, FULL_DROP});
      directed_steps.push_back('{dris_pkg::MODE_INSERT, 8'h80, 8'h0F, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_REMOVE, 8'h7F, 8'h04, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_REMOVE, 8'h00, 8'h00, 1'b0, ANY_RESULT});
      directed_steps.push_back('{dris_pkg::MODE_REMOVE, 8'hF0, 8'h0D, 1'b0, ANY_RESULT});
      directed_steps.push_back('{MODE_QUERY,            8'hF0, 8'h0E, 1'b0, ANY_RESULT});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         drive_req(directed_steps[i].mode, directed_steps[i].reg_id,
                   directed_steps[i].read_index, directed_steps[i].typed,
                   directed_steps[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         hold_until_drained();
         case (phase)
            0: cfg = 8'h00;
            1: cfg = 8'hFF;
            2: cfg = (set_count > 0) ? set_ids[0] : 8'h42;
            4: cfg = 8'h80;
            default: cfg = 8'($urandom);
         endcase
         write_invalid_id(cfg);
         foreach (id_pool[k]) id_pool[k] = 8'($urandom);
         insert_bias = 45;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n % 64 == 0) insert_bias = $urandom_range(25, 60);
            sel = $urandom_range(0, 99);
            if (sel < insert_bias) mode = dris_pkg::MODE_INSERT;
            else if (sel < 80) mode = dris_pkg::MODE_REMOVE;
            else if (sel < 95) mode = MODE_QUERY;
            else mode = MODE_SPARE;
            sel = $urandom_range(0, 99);
            if (sel < 55) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (sel < 75 && set_count > 0) id = set_ids[$urandom_range(0, set_count - 1)];
            else if (sel < 82) id = invalid_id_q;
            else id = 8'($urandom_range(0, 255));
            sel = $urandom_range(0, 99);
            if (sel < 70) idx = 8'($urandom_range(0, set_count));
            else if (sel < 85) idx = 8'($urandom_range(0, dris_pkg::MAX_ENTRIES - 1));
            else idx = 8'($urandom_range(0, 255));
            drive_req(mode, id, idx, 1'b0, ANY_RESULT);
            if ($urandom_range(0, 249) == 0) hold_until_drained();
         end
      end

      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (pending_set_results.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (pending_set_results.size() != 0) begin
         $error("%0d result words never arrived", pending_set_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("dedup_register_id_set verification clean");
      else
         $display("dedup_register_id_set verification failed");
      $finish;
   end

endmodule
